// File: rtl/mfsd_pkg.sv
// Shared types, codes and constants of the magnet field sweep DAC controller.
package mfsd_pkg;

    localparam int ZVF_W   = 30;
    localparam int SLOPE_W = 28;
    localparam int FIELD_W = 32;
    localparam int EXT_W   = 34;
    localparam int DAC_W   = 20;
    localparam int CMD_W   = 3;
    localparam int STAT_W  = 3;
    localparam int APB_AW  = 5;
    localparam int APB_DW  = 32;

    localparam logic [DAC_W-1:0] DAC_MAX = 20'd655360;
    // 65536 = 2**16 fractional scaling of the DAC code.
    localparam int VOLT_FRAC_SH = 16;
    // Quotient bits produced by the divider before saturation.
    localparam int DIV_STEPS = 21;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam int DIV_HIGH_W = FIELD_W + VOLT_FRAC_SH - DIV_STEPS;

    localparam logic signed [SLOPE_W-1:0] SLOPE_RESET = 28'sd1000;
    localparam logic signed [EXT_W-1:0] FIELD_MAX_EXT = 34'sd2147483647;

    localparam logic [2:0] REG_ZVF       = 3'd0;
    localparam logic [2:0] REG_SLOPE     = 3'd1;
    localparam logic [2:0] REG_START     = 3'd2;
    localparam logic [2:0] REG_STEP      = 3'd3;
    localparam logic [2:0] REG_START_DEF = 3'd4;
    localparam logic [2:0] REG_STRICT    = 3'd5;

    typedef enum logic [CMD_W-1:0] {
        CMD_SET   = 3'd0,
        CMD_UP    = 3'd1,
        CMD_DOWN  = 3'd2,
        CMD_START = 3'd3,
        CMD_READ  = 3'd4
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 3'd0,
        ST_CLAMP   = 3'd1,
        ST_RANGE   = 3'd2,
        ST_NOSETUP = 3'd3,
        ST_UNSET   = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_LIMIT,
        SEQ_APPLY,
        SEQ_DAC,
        SEQ_DIV,
        SEQ_DONE
    } t_seq_state;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_DONE
    } t_div_state;

    typedef struct packed {
        logic               start;
        logic [FIELD_W-1:0] num_mag;
        logic [SLOPE_W-1:0] den_mag;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DAC_W-1:0] quot;
    } t_div_rsp;

endpackage

// File: rtl/mfsd_cmd_if.sv
// Command channel: valid/ready handshake carrying one command item.
interface mfsd_cmd_if import mfsd_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [CMD_W-1:0]          cmd;
    logic signed [FIELD_W-1:0] target_field;

    modport source (output valid, cmd, target_field, input ready);
    modport sink   (input valid, cmd, target_field, output ready);
endinterface

// File: rtl/mfsd_res_if.sv
// Result channel: valid/ready handshake carrying one result item.
interface mfsd_res_if import mfsd_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [STAT_W-1:0]         status;
    logic signed [FIELD_W-1:0] field_now;
    logic [DAC_W-1:0]          dac_voltage;
    logic                      dac_write;

    modport source (output valid, status, field_now, dac_voltage, dac_write, input ready);
    modport sink   (input valid, status, field_now, dac_voltage, dac_write, output ready);
endinterface

// File: rtl/mfsd_div.sv
// Restoring divider for the DAC code: |field offset| * 65536 / |slope|, saturated.
module mfsd_div import mfsd_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    t_div_state             r_state, n_state;
    logic [DIV_CNT_W-1:0]   r_cnt, n_cnt;
    logic [SLOPE_W-1:0]     r_rem, n_rem;
    logic [SLOPE_W-1:0]     r_den, n_den;
    logic [DIV_STEPS-1:0]   r_low, n_low;
    logic [DIV_STEPS-1:0]   r_quot, n_quot;
    logic                   r_ovf, n_ovf;

    logic [DIV_HIGH_W-1:0]  w_high;
    logic [SLOPE_W+1:0]     w_trial;
    logic                   w_ge;

    // The numerator is num_mag shifted up by 16; its top part must stay below the
    // divisor for the quotient to fit, otherwise the code saturates at once.
    assign w_high  = i_req.num_mag[FIELD_W-1:DIV_STEPS-VOLT_FRAC_SH];
    assign w_trial = {1'b0, r_rem, r_low[DIV_STEPS-1]} - {2'b00, r_den};
    assign w_ge    = !w_trial[SLOPE_W+1];

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_den   = r_den;
        n_low   = r_low;
        n_quot  = r_quot;
        n_ovf   = r_ovf;
        case (r_state)
            DIV_IDLE: begin
                if (i_req.start) begin
                    n_den  = i_req.den_mag;
                    n_rem  = SLOPE_W'(w_high);
                    n_low  = {i_req.num_mag[DIV_STEPS-VOLT_FRAC_SH-1:0], {VOLT_FRAC_SH{1'b0}}};
                    n_quot = '0;
                    n_cnt  = '0;
                    n_ovf  = ({1'b0, w_high} >= i_req.den_mag);
                    n_state = n_ovf ? DIV_DONE : DIV_RUN;
                end
            end
            DIV_RUN: begin
                n_rem  = w_ge ? w_trial[SLOPE_W-1:0] : {r_rem[SLOPE_W-2:0], r_low[DIV_STEPS-1]};
                n_low  = {r_low[DIV_STEPS-2:0], 1'b0};
                n_quot = {r_quot[DIV_STEPS-2:0], w_ge};
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    n_state = DIV_DONE;
                end
            end
            DIV_DONE: begin
                n_state = DIV_IDLE;
            end
            default: begin
                n_state = DIV_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DIV_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_cnt  <= n_cnt;
        r_rem  <= n_rem;
        r_den  <= n_den;
        r_low  <= n_low;
        r_quot <= n_quot;
        r_ovf  <= n_ovf;
    end

    always_comb begin
        o_rsp.done = (r_state == DIV_DONE);
        if (r_ovf || r_quot > {1'b0, DAC_MAX}) begin
            o_rsp.quot = DAC_MAX;
        end else begin
            o_rsp.quot = r_quot[DAC_W-1:0];
        end
    end

endmodule

// File: rtl/magnet_field_sweep_dac_unit.sv
// Top level of the magnet field sweep DAC controller: registers, command sequencer, output stage.
// Set, sweep and go-to-start pass limit, apply, DAC, divide and done, where the 21-step shared
// restoring divider forms the DAC code; read and not-set-up skip limit and apply, a zero
// slope skips apply and divide, a zero code skips divide; early saturation cuts the divider short.
// Throughput: one item in work at a time; ready returns in the cycle the result turns valid,
// and the result register lets the next item enter while it waits. Synchronous active-low reset.
module magnet_field_sweep_dac_unit import mfsd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    mfsd_cmd_if.sink          i_cmd,
    mfsd_res_if.source        o_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic [ZVF_W-1:0]          r_zvf;
    logic signed [SLOPE_W-1:0] r_slope;
    logic signed [FIELD_W-1:0] r_start;
    logic signed [SLOPE_W-1:0] r_step;
    logic                      r_start_def;
    logic                      r_strict;

    t_seq_state                r_state, n_state;
    logic signed [FIELD_W-1:0] r_cur, n_cur;
    logic                      r_fvalid, n_fvalid;
    logic signed [EXT_W-1:0]   r_cand, n_cand;
    logic signed [EXT_W-1:0]   r_lo, n_lo;
    logic signed [EXT_W-1:0]   r_hi, n_hi;
    logic [STAT_W-1:0]         r_status, n_status;
    logic                      r_write, n_write;
    logic [DAC_W-1:0]          r_dac, n_dac;

    logic                      r_out_valid, n_out_valid;
    logic [STAT_W-1:0]         r_out_status, n_out_status;
    logic signed [FIELD_W-1:0] r_out_field, n_out_field;
    logic [DAC_W-1:0]          r_out_dac, n_out_dac;
    logic                      r_out_write, n_out_write;

    logic                      w_cfg_wr;
    logic [2:0]                w_cfg_idx;
    logic                      w_accept;
    logic signed [EXT_W-1:0]   w_zvf_ext;
    logic signed [EXT_W-1:0]   w_slope_ext;
    logic signed [EXT_W-1:0]   w_end;
    logic signed [EXT_W-1:0]   w_cur_ext;
    logic signed [EXT_W-1:0]   w_step_ext;
    logic signed [FIELD_W:0]   w_diff;
    logic [FIELD_W:0]          w_diff_mag;
    logic [SLOPE_W-1:0]        w_slope_mag;
    logic                      w_below;
    logic                      w_above;
    t_div_req                  w_div_req;
    t_div_rsp                  w_div_rsp;

    // Configuration port.
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_cfg_idx = paddr[APB_AW-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zvf       <= '0;
            r_slope     <= SLOPE_RESET;
            r_start     <= '0;
            r_step      <= '0;
            r_start_def <= 1'b0;
            r_strict    <= 1'b0;
        end else if (w_cfg_wr) begin
            case (w_cfg_idx)
                REG_ZVF:       r_zvf       <= pwdata[ZVF_W-1:0];
                REG_SLOPE:     r_slope     <= pwdata[SLOPE_W-1:0];
                REG_START:     r_start     <= pwdata[FIELD_W-1:0];
                REG_STEP:      r_step      <= pwdata[SLOPE_W-1:0];
                REG_START_DEF: r_start_def <= pwdata[0];
                REG_STRICT:    r_strict    <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_cfg_idx)
            REG_ZVF:       prdata = APB_DW'(r_zvf);
            REG_SLOPE:     prdata = APB_DW'(r_slope);
            REG_START:     prdata = APB_DW'(r_start);
            REG_STEP:      prdata = APB_DW'(r_step);
            REG_START_DEF: prdata = APB_DW'(r_start_def);
            REG_STRICT:    prdata = APB_DW'(r_strict);
            default:       prdata = '0;
        endcase
    end

    // Span arithmetic: end = zero_volt_field + 10 * slope, 10x as two shifted adds.
    assign w_zvf_ext   = EXT_W'(r_zvf);
    assign w_slope_ext = EXT_W'(r_slope);
    assign w_end       = w_zvf_ext + (w_slope_ext <<< 3) + (w_slope_ext <<< 1);
    assign w_cur_ext   = EXT_W'(r_cur);
    assign w_step_ext  = EXT_W'(r_step);
    assign w_below     = (r_cand < r_lo);
    assign w_above     = (r_cand > r_hi);

    assign w_diff      = (FIELD_W + 1)'(r_cur) - (FIELD_W + 1)'(signed'({1'b0, r_zvf}));
    assign w_diff_mag  = w_diff[FIELD_W] ? (FIELD_W + 1)'(-w_diff) : w_diff;
    assign w_slope_mag = r_slope[SLOPE_W-1] ? SLOPE_W'(-r_slope) : r_slope;

    assign w_accept      = i_cmd.valid && i_cmd.ready;
    assign i_cmd.ready   = (r_state == SEQ_IDLE);

    always_comb begin
        n_state      = r_state;
        n_cur        = r_cur;
        n_fvalid     = r_fvalid;
        n_cand       = r_cand;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_status     = r_status;
        n_write      = r_write;
        n_dac        = r_dac;
        n_out_valid  = r_out_valid && !o_res.ready;
        n_out_status = r_out_status;
        n_out_field  = r_out_field;
        n_out_dac    = r_out_dac;
        n_out_write  = r_out_write;
        w_div_req.start   = 1'b0;
        w_div_req.num_mag = w_diff_mag[FIELD_W-1:0];
        w_div_req.den_mag = w_slope_mag;
        case (r_state)
            SEQ_IDLE: begin
                if (w_accept) begin
                    n_write = 1'b0;
                    case (i_cmd.cmd)
                        CMD_SET: begin
                            n_cand  = EXT_W'(i_cmd.target_field);
                            n_state = SEQ_LIMIT;
                        end
                        CMD_UP, CMD_DOWN: begin
                            if (r_start_def) begin
                                n_cand  = (i_cmd.cmd == CMD_UP) ? w_cur_ext + w_step_ext
                                                                : w_cur_ext - w_step_ext;
                                n_state = SEQ_LIMIT;
                            end else begin
                                n_status = ST_NOSETUP;
                                n_state  = SEQ_DAC;
                            end
                        end
                        CMD_START: begin
                            if (r_start_def) begin
                                n_cand  = EXT_W'(r_start);
                                n_state = SEQ_LIMIT;
                            end else begin
                                n_status = ST_NOSETUP;
                                n_state  = SEQ_DAC;
                            end
                        end
                        default: begin
                            // Read, and the unused codes that behave as read.
                            n_status = r_fvalid ? ST_OK : ST_UNSET;
                            n_state  = SEQ_DAC;
                        end
                    endcase
                end
            end
            SEQ_LIMIT: begin
                if (r_slope == '0) begin
                    n_status = ST_RANGE;
                    n_state  = SEQ_DAC;
                end else begin
                    if (r_slope[SLOPE_W-1]) begin
                        n_lo = w_end;
                        n_hi = w_zvf_ext;
                    end else begin
                        n_lo = w_zvf_ext;
                        n_hi = (w_end > FIELD_MAX_EXT) ? FIELD_MAX_EXT : w_end;
                    end
                    n_state = SEQ_APPLY;
                end
            end
            SEQ_APPLY: begin
                n_state = SEQ_DAC;
                if (!w_below && !w_above) begin
                    n_cur    = r_cand[FIELD_W-1:0];
                    n_fvalid = 1'b1;
                    n_status = ST_OK;
                    n_write  = 1'b1;
                end else if (r_strict) begin
                    n_status = ST_RANGE;
                end else begin
                    n_cur    = w_below ? r_lo[FIELD_W-1:0] : r_hi[FIELD_W-1:0];
                    n_fvalid = 1'b1;
                    n_status = ST_CLAMP;
                    n_write  = 1'b1;
                end
            end
            SEQ_DAC: begin
                // Opposite signs give a negative quotient, which reads as zero volts.
                if (!r_fvalid || r_slope == '0 || w_diff == '0 ||
                    (w_diff[FIELD_W] != r_slope[SLOPE_W-1])) begin
                    n_dac   = '0;
                    n_state = SEQ_DONE;
                end else begin
                    w_div_req.start = 1'b1;
                    n_state         = SEQ_DIV;
                end
            end
            SEQ_DIV: begin
                if (w_div_rsp.done) begin
                    n_dac   = w_div_rsp.quot;
                    n_state = SEQ_DONE;
                end
            end
            SEQ_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_field  = r_cur;
                    n_out_dac    = r_dac;
                    n_out_write  = r_write;
                    n_state      = SEQ_IDLE;
                end
            end
            default: begin
                n_state = SEQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= SEQ_IDLE;
            r_cur       <= '0;
            r_fvalid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cur       <= n_cur;
            r_fvalid    <= n_fvalid;
            r_out_valid <= n_out_valid;
        end
        r_cand       <= n_cand;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_status     <= n_status;
        r_write      <= n_write;
        r_dac        <= n_dac;
        r_out_status <= n_out_status;
        r_out_field  <= n_out_field;
        r_out_dac    <= n_out_dac;
        r_out_write  <= n_out_write;
    end

    mfsd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign o_res.valid       = r_out_valid;
    assign o_res.status      = r_out_status;
    assign o_res.field_now   = r_out_field;
    assign o_res.dac_voltage = r_out_dac;
    assign o_res.dac_write   = r_out_write;

`ifndef NO_ASSERTIONS
    a_write_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_write) |-> (r_out_status == ST_OK || r_out_status == ST_CLAMP))
        else $error("DAC write flagged on a result that did not apply a field");

    a_dac_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_dac <= DAC_MAX))
        else $error("DAC code above full scale");

    a_unset_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == ST_UNSET) |-> (r_out_field == '0 && r_out_dac == '0))
        else $error("Unset field reported with nonzero field or voltage");

    a_write_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_write) |-> r_fvalid)
        else $error("Field written but field-valid flag is clear");
`endif

endmodule
